// File: src/hcb_pkg.sv
// Shared constants and types for the Huffman code builder.
package hcb_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int FREQ_BITS   = 16;

    localparam int NODE_CAP = 2 * MAX_SYMBOLS - 1;
    localparam int NODE_W   = $clog2(NODE_CAP + 1);
    localparam int CNT_W    = $clog2(MAX_SYMBOLS + 1);
    localparam int LEAF_W   = $clog2(MAX_SYMBOLS);
    localparam int SP_W     = $clog2(MAX_SYMBOLS);
    localparam int WEIGHT_W = FREQ_BITS + $clog2(MAX_SYMBOLS);

    localparam int SYM_W  = 8;
    localparam int FIN_W  = 16;
    localparam int CODE_W = 15;
    localparam int LEN_W  = 4;

    localparam logic [31:0] FREQ_MASK = (FREQ_BITS >= 32) ? 32'hFFFF_FFFF :
                                        32'((64'd1 << FREQ_BITS) - 64'd1);

    typedef struct packed {
        logic load;
        logic init;
        logic scan_step;
        logic merge;
        logic walk_start;
        logic walk_step;
    } hcb_cmd_t;

    typedef struct packed {
        logic multi;
        logic scan_done;
        logic more_merges;
        logic top_leaf;
        logic stack_empty;
        logic out_free;
    } hcb_status_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } hcb_walk_t;

endpackage

// File: src/hcb_ctrl.sv
// Sequencer for loading, merging and the preorder walk.
module hcb_ctrl
    import hcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        last,
    output logic        in_stall,
    input  hcb_status_t status,
    output hcb_cmd_t    cmd
);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MERGE = 3'd3;
    localparam logic [2:0] S_ROOT  = 3'd4;
    localparam logic [2:0] S_WALK  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_LOAD);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (last)
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = status.multi ? S_SCAN : S_ROOT;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                cmd.merge  = 1'b1;
                state_next = status.more_merges ? S_SCAN : S_ROOT;
            end
            S_ROOT:
            begin
                cmd.walk_start = 1'b1;
                state_next     = S_WALK;
            end
            S_WALK:
            begin
                if (!status.top_leaf || status.out_free)
                begin
                    cmd.walk_step = 1'b1;
                    if (status.top_leaf && status.stack_empty)
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_LOAD)
        else $error("A word was taken outside the load state.");

    a_build_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && last |=> state_reg == S_INIT)
        else $error("The last word did not start a build.");

    a_walk_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK && state_next == S_LOAD |-> status.out_free)
        else $error("The walk finished without room for its final code word.");

endmodule

// File: src/hcb_dp.sv
// Node store, two-minimum scan, merge unit, walk stack and output register.
module hcb_dp
    import hcb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  hcb_cmd_t            cmd,
    output hcb_status_t         status,
    input  logic [SYM_W-1:0]    symbol,
    input  logic [FIN_W-1:0]    frequency,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SYM_W-1:0]    code_symbol,
    output logic [CODE_W-1:0]   code_bits,
    output logic [LEN_W-1:0]    code_length,
    output logic                dropped,
    output logic                final_res
);

    logic [WEIGHT_W-1:0] weight_mem [NODE_CAP];
    logic [SYM_W-1:0]    sym_mem    [MAX_SYMBOLS];
    logic [NODE_W-1:0]   left_mem   [NODE_CAP];
    logic [NODE_W-1:0]   right_mem  [NODE_CAP];
    hcb_walk_t           stack_mem  [MAX_SYMBOLS];
    logic [NODE_CAP-1:0] active_reg;

    logic [CNT_W-1:0]    leaf_count_reg;
    logic                overflow_reg;
    logic [NODE_W-1:0]   total_reg;
    logic [NODE_W-1:0]   remaining_reg;
    logic [NODE_W-1:0]   scan_reg;
    logic [NODE_W-1:0]   best_reg;
    logic [NODE_W-1:0]   second_reg;
    logic                best_ok_reg;
    logic                second_ok_reg;
    logic [WEIGHT_W-1:0] best_w_reg;
    logic [WEIGHT_W-1:0] second_w_reg;
    hcb_walk_t           top_reg;
    logic [SP_W-1:0]     sp_reg;

    logic                out_valid_reg;
    logic [SYM_W-1:0]    out_sym_reg;
    logic [CODE_W-1:0]   out_code_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic                out_drop_reg;
    logic                out_final_reg;

    logic [31:0]         freq_ext;
    logic                top_leaf;
    logic                emit;
    logic [NODE_W-1:0]   leaf_nodes;

    assign freq_ext   = 32'(frequency) & FREQ_MASK;
    assign leaf_nodes = NODE_W'(leaf_count_reg);
    assign top_leaf   = (top_reg.node < leaf_nodes);
    assign emit       = cmd.walk_step && top_leaf;

    assign status.multi       = (leaf_count_reg > CNT_W'(1));
    assign status.scan_done   = (scan_reg == total_reg - NODE_W'(1));
    assign status.more_merges = (remaining_reg > NODE_W'(2));
    assign status.top_leaf    = top_leaf;
    assign status.stack_empty = (sp_reg == '0);
    assign status.out_free    = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.load && leaf_count_reg < CNT_W'(MAX_SYMBOLS))
        begin
            weight_mem[leaf_nodes]             <= WEIGHT_W'(freq_ext);
            sym_mem[leaf_count_reg[LEAF_W-1:0]] <= symbol;
        end
        if (cmd.merge)
        begin
            weight_mem[total_reg] <= best_w_reg + second_w_reg;
            left_mem[total_reg]   <= best_reg;
            right_mem[total_reg]  <= second_reg;
        end
        if (cmd.walk_step && !top_leaf)
        begin
            stack_mem[sp_reg] <= '{node: right_mem[top_reg.node],
                                   code: {top_reg.code[CODE_W-2:0], 1'b1},
                                   len:  top_reg.len + LEN_W'(1)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            leaf_count_reg <= '0;
            overflow_reg   <= 1'b0;
            total_reg      <= '0;
            remaining_reg  <= '0;
            scan_reg       <= '0;
            best_reg       <= '0;
            second_reg     <= '0;
            best_ok_reg    <= 1'b0;
            second_ok_reg  <= 1'b0;
            best_w_reg     <= '0;
            second_w_reg   <= '0;
            top_reg        <= '0;
            sp_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (leaf_count_reg < CNT_W'(MAX_SYMBOLS))
                begin
                    leaf_count_reg <= leaf_count_reg + CNT_W'(1);
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end
            if (cmd.init)
            begin
                for (int i = 0; i < NODE_CAP; i++)
                begin
                    active_reg[i] <= (NODE_W'(i) < leaf_nodes);
                end
                total_reg     <= leaf_nodes;
                remaining_reg <= leaf_nodes;
            end
            if (cmd.init || cmd.merge)
            begin
                scan_reg      <= '0;
                best_ok_reg   <= 1'b0;
                second_ok_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + NODE_W'(1);
                if (active_reg[scan_reg])
                begin
                    if (!best_ok_reg || weight_mem[scan_reg] < best_w_reg)
                    begin
                        best_reg      <= scan_reg;
                        best_w_reg    <= weight_mem[scan_reg];
                        best_ok_reg   <= 1'b1;
                        second_reg    <= best_reg;
                        second_w_reg  <= best_w_reg;
                        second_ok_reg <= best_ok_reg;
                    end
                    else if (!second_ok_reg || weight_mem[scan_reg] < second_w_reg)
                    begin
                        second_reg    <= scan_reg;
                        second_w_reg  <= weight_mem[scan_reg];
                        second_ok_reg <= 1'b1;
                    end
                end
            end
            if (cmd.merge)
            begin
                active_reg[best_reg]   <= 1'b0;
                active_reg[second_reg] <= 1'b0;
                active_reg[total_reg]  <= 1'b1;
                total_reg              <= total_reg + NODE_W'(1);
                remaining_reg          <= remaining_reg - NODE_W'(1);
            end
            if (cmd.walk_start)
            begin
                top_reg <= '{node: total_reg - NODE_W'(1), code: '0, len: '0};
                sp_reg  <= '0;
            end
            if (cmd.walk_step)
            begin
                if (!top_leaf)
                begin
                    top_reg <= '{node: left_mem[top_reg.node],
                                 code: {top_reg.code[CODE_W-2:0], 1'b0},
                                 len:  top_reg.len + LEN_W'(1)};
                    sp_reg  <= sp_reg + SP_W'(1);
                end
                else if (sp_reg != '0)
                begin
                    top_reg <= stack_mem[sp_reg - SP_W'(1)];
                    sp_reg  <= sp_reg - SP_W'(1);
                end
                else
                begin
                    leaf_count_reg <= '0;
                    overflow_reg   <= 1'b0;
                    active_reg     <= '0;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_sym_reg   <= sym_mem[top_reg.node[LEAF_W-1:0]];
            out_code_reg  <= top_reg.code;
            out_len_reg   <= top_reg.len;
            out_drop_reg  <= overflow_reg;
            out_final_reg <= (sp_reg == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign code_symbol = out_sym_reg;
    assign code_bits   = out_code_reg;
    assign code_length = out_len_reg;
    assign dropped     = out_drop_reg;
    assign final_res   = out_final_reg;

    a_merge_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge |-> total_reg < NODE_W'(NODE_CAP) && best_ok_reg && second_ok_reg)
        else $error("A merge ran without two candidates or without room.");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !out_valid_reg || !out_stall)
        else $error("A code word overwrote one still waiting.");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step && !top_leaf |-> sp_reg < SP_W'(MAX_SYMBOLS - 1))
        else $error("The walk stack overflowed.");

endmodule

// File: src/huffman_code_builder_top.sv
// Top level of the Huffman code builder.
//
// Words arrive on the input channel (in_valid, in_stall), one symbol and its
// frequency each; the word with last set closes the set and starts the build.
// Up to 16 symbols are held; further words are taken but discarded, and every
// code word of that set then shows dropped.
// A word that is not last is taken as soon as it is offered. The last word is
// followed by a set-up step, then for each of the N-1 merges a scan over all
// nodes created so far (one node a cycle through the two-minimum comparator)
// and a merge step, then a step to seat the root and one walk step per tree
// node, while N code words leave in preorder on the output channel (out_valid,
// out_stall), the final one marked by final_res.
// The input is stalled from the last word until the final code word has been
// written to the output register. A stalled output register holds its word
// and pauses the walk at the next leaf.
// Reset clears the sequencer, the symbol count and the output valid flag.
module huffman_code_builder_top
    import hcb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [SYM_W-1:0]  symbol,
    input  logic [FIN_W-1:0]  frequency,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [SYM_W-1:0]  code_symbol,
    output logic [CODE_W-1:0] code_bits,
    output logic [LEN_W-1:0]  code_length,
    output logic              dropped,
    output logic              final_res
);

    hcb_cmd_t    cmd;
    hcb_status_t status;

    hcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    hcb_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .symbol      (symbol),
        .frequency   (frequency),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_symbol (code_symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .dropped     (dropped),
        .final_res   (final_res)
    );

endmodule

// File: verif/huffman_code_checker.sv
// Checker for the Huffman code builder: watches both channels, predicts code words and compares.
module huffman_code_checker
    import hcb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [SYM_W-1:0]  symbol,
    input  logic [FIN_W-1:0]  frequency,
    input  logic              last,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [SYM_W-1:0]  code_symbol,
    input  logic [CODE_W-1:0] code_bits,
    input  logic [LEN_W-1:0]  code_length,
    input  logic              dropped,
    input  logic              final_res,
    output int                fail_count,
    output int                pending_codes
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  len;
        logic              drop;
        logic              fin;
    } code_word_t;

    localparam int TREE_CAP = 2 * MAX_SYMBOLS;

    code_word_t  expected_codes[$];
    logic [63:0] weight[TREE_CAP];
    logic [7:0]  leaf_sym[TREE_CAP];
    bit          internal[TREE_CAP];
    bit          alive[TREE_CAP];
    int          lchild[TREE_CAP];
    int          rchild[TREE_CAP];
    int          held;
    bit          overflow;

    assign pending_codes = expected_codes.size();

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    function automatic int least_alive(input int total);
        int best;
        best = -1;
        for (int i = 0; i < total; i++)
            if (alive[i] && (best < 0 || weight[i] < weight[best]))
                best = i;
        return best;
    endfunction

    task automatic build_codes();
        int total, a, b, n, count;
        int stk[$];
        logic [63:0] cstk[$];
        int lstk[$];
        logic [63:0] c;
        int l;
        code_word_t w;
        total = held;
        for (int i = 0; i < TREE_CAP; i++)
            alive[i] = (i < total);
        for (int r = total; r > 1; r--)
        begin
            a = least_alive(total);
            alive[a] = 0;
            b = least_alive(total);
            alive[b] = 0;
            weight[total] = weight[a] + weight[b];
            internal[total] = 1;
            lchild[total] = a;
            rchild[total] = b;
            alive[total] = 1;
            total++;
        end
        count = 0;
        stk.push_back(total - 1);
        cstk.push_back(64'd0);
        lstk.push_back(0);
        while (stk.size() > 0)
        begin
            n = stk.pop_back();
            c = cstk.pop_back();
            l = lstk.pop_back();
            if (internal[n])
            begin
                stk.push_back(rchild[n]);
                cstk.push_back((c << 1) | 64'd1);
                lstk.push_back(l + 1);
                stk.push_back(lchild[n]);
                cstk.push_back(c << 1);
                lstk.push_back(l + 1);
            end
            else
            begin
                w.sym = leaf_sym[n];
                w.bits = c[CODE_W-1:0];
                w.len = l[LEN_W-1:0];
                w.drop = overflow;
                w.fin = 0;
                expected_codes.push_back(w);
                count++;
            end
        end
        if (count > 0)
            expected_codes[$].fin = 1;
        held = 0;
        overflow = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        code_word_t e;
        if (!rst_n)
        begin
            held = 0;
            overflow = 0;
            fail_count = 0;
            expected_codes.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_codes.size() == 0)
                    report_mismatch("code word with none expected");
                else
                begin
                    e = expected_codes.pop_front();
                    if (code_symbol !== e.sym)
                        report_mismatch($sformatf("symbol %0d, wanted %0d", code_symbol, e.sym));
                    if (code_bits !== e.bits)
                        report_mismatch($sformatf("bits %h, wanted %h", code_bits, e.bits));
                    if (code_length !== e.len)
                        report_mismatch($sformatf("length %0d, wanted %0d", code_length, e.len));
                    if (dropped !== e.drop)
                        report_mismatch($sformatf("dropped %b, wanted %b", dropped, e.drop));
                    if (final_res !== e.fin)
                        report_mismatch($sformatf("final %b, wanted %b", final_res, e.fin));
                end
            end
            if (in_valid && !in_stall)
            begin
                if (held < MAX_SYMBOLS)
                begin
                    leaf_sym[held] = symbol;
                    weight[held] = 64'(frequency) & 64'(FREQ_MASK);
                    internal[held] = 0;
                    held++;
                end
                else
                    overflow = 1;
                if (last)
                    build_codes();
            end
        end
    end
endmodule

// File: verif/tb_huffman_code_builder_top.sv
// Testbench top for the Huffman code builder: stimulus, idling phases and verdict.
module tb_huffman_code_builder_top;
    import hcb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 20000;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              in_valid = 0;
    logic              in_stall;
    logic [SYM_W-1:0]  symbol = 0;
    logic [FIN_W-1:0]  frequency = 0;
    logic              last = 0;
    logic              out_valid;
    logic              out_stall = 0;
    logic [SYM_W-1:0]  code_symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              dropped;
    logic              final_res;
    int                fail_count;
    int                pending_codes;
    int                send_idle_pct = 0;
    int                stall_pct = 0;
    int                quiet_cycles = 0;

    huffman_code_builder_top dut (.*);
    huffman_code_checker checker_i (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Drives one word, honouring the sender idling rate, and waits until it is taken.
    task automatic send_word(input logic [7:0] s, input logic [15:0] f, input logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        symbol <= s;
        frequency <= f;
        last <= l;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_set(input int n, input int kind);
        logic [15:0] f;
        for (int i = 0; i < n; i++)
        begin
            case (kind)
                0: f = 16'($urandom);
                1: f = 16'($urandom_range(3));
                default: f = 16'(1) << $urandom_range(15);
            endcase
            send_word(8'($urandom), f, i == n - 1);
        end
    endtask

    initial
    begin
        int n, sent;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_word(8'd36, 16'hFFFF, 1'b1);
        send_word(8'd0, 16'd0, 1'b0);
        send_word(8'd255, 16'd0, 1'b1);
        send_word(8'd36, 16'd5, 1'b0);
        send_word(8'd1, 16'd5, 1'b0);
        send_word(8'd2, 16'd5, 1'b1);
        for (int i = 0; i < 18; i++)
            send_word(8'(i * 15), 16'(1) << (i % 16), i == 17);
        sent = 24;
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 68 : 38) : 0;
            stall_pct = (phase == 2) ? 68 : ((phase == 3) ? 38 : 0);
            while (sent < 24 + (phase + 1) * 102)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 8);
                send_set(n, $urandom_range(2));
                sent += n;
            end
            in_valid <= 0;
            @(posedge clk);
            while (pending_codes != 0)
                @(posedge clk);
        end
        stall_pct = 0;
        while (pending_codes != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// File: filelist.f
src/hcb_pkg.sv
src/hcb_ctrl.sv
src/hcb_dp.sv
src/huffman_code_builder_top.sv
verif/huffman_code_checker.sv
verif/tb_huffman_code_builder_top.sv
